@@ src/bdll_pkg.sv @@
// shared types and constants for the button debounce and light latch unit
`timescale 1ns / 1ps
`default_nettype none

package bdll_pkg;

  localparam int BtnFieldW   = 5;
  localparam int LightFieldW = 4;
  localparam int ActFieldW   = 8;
  localparam int StateW      = 2;
  localparam int ActW        = 2;

  localparam int DefButtonCount   = 5;
  localparam int DefLightCount    = 4;
  localparam int DefDebounceTicks = 10;

  localparam logic [StateW-1:0] StateFlip = 2'b11;

  typedef enum logic {
    CmdScan  = 1'b0,
    CmdLight = 1'b1
  } cmd_e;

  typedef enum logic [ActW-1:0] {
    ActKeep   = 2'd0,
    ActOff    = 2'd1,
    ActOn     = 2'd2,
    ActToggle = 2'd3
  } light_act_e;

  typedef struct packed {
    logic                 command;
    logic [BtnFieldW-1:0] button_levels;
    logic [ActFieldW-1:0] light_actions;
  } req_t;

  typedef struct packed {
    logic [LightFieldW-1:0]      light_pattern;
    logic                        report_valid;
    logic [2*BtnFieldW-1:0]      report_states;
    logic [BtnFieldW-1:0]        tracked_levels;
  } rsp_t;

endpackage

`default_nettype wire

@@ src/button_debounce_light_latch_unit.sv @@
// top level: shared-timer button debouncer with a latched light register
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o   in_req_i (req_t)
//   out      output     out_valid_o / out_ready_i out_rsp_o (rsp_t)
//   cfg      input      cfg_we_i (no wait)        cfg_wdata_i (report enable)
//
// one request per cycle sustained while out_ready_i keeps the result moving
// a request lands in the input register, the next-state logic runs once and
// writes button state, countdown, lights and the result register together
// reset clears button states, countdown, lights and report enable
// a stalled result holds; the input register still takes one more request
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_light_latch_unit
  import bdll_pkg::*;
#(
  parameter int BUTTON_COUNT   = DefButtonCount,
  parameter int LIGHT_COUNT    = DefLightCount,
  parameter int DEBOUNCE_TICKS = DefDebounceTicks
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output rsp_t      out_rsp_o,
  input  wire       cfg_we_i,
  input  wire       cfg_wdata_i
);

  localparam int RptBtn    = (BUTTON_COUNT < BtnFieldW) ? BUTTON_COUNT : BtnFieldW;
  localparam int ActLights = (LIGHT_COUNT < ActFieldW / ActW) ? LIGHT_COUNT
                                                              : ActFieldW / ActW;
  localparam int OutLights = (LIGHT_COUNT < LightFieldW) ? LIGHT_COUNT : LightFieldW;
  localparam int CntW      = $clog2(DEBOUNCE_TICKS + 1);

  req_t                    req_q;
  logic                    req_vld_q;
  rsp_t                    rsp_q, rsp_d;
  logic                    rsp_vld_q;
  logic                    rpt_en_q;
  logic [StateW-1:0]       btn_q [BUTTON_COUNT];
  logic [StateW-1:0]       btn_d [BUTTON_COUNT];
  logic [StateW-1:0]       btn_mid [BUTTON_COUNT];
  logic [CntW-1:0]         cnt_q, cnt_d, cnt_mid;
  logic                    idle_q, idle_d, idle_mid;
  logic [LIGHT_COUNT-1:0]  light_q, light_d;
  logic [BUTTON_COUNT-1:0] lvl, flip;
  logic                    settle_done;
  logic                    is_scan;
  logic                    advance, fire;

  assign advance     = !rsp_vld_q || out_ready_i;
  assign fire        = req_vld_q && advance;
  assign in_ready_o  = !req_vld_q || advance;
  assign out_valid_o = rsp_vld_q;
  assign out_rsp_o   = rsp_q;
  assign is_scan     = (req_q.command == CmdScan);

  always_comb begin
    lvl = '0;
    for (int i = 0; i < RptBtn; i++) begin
      lvl[i] = req_q.button_levels[i];
    end
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      flip[i]    = btn_q[i][0] ^ lvl[i];
      btn_mid[i] = flip[i] ? (btn_q[i] ^ StateFlip) : btn_q[i];
    end
    // any level change restarts the shared countdown
    cnt_mid     = (|flip) ? CntW'(DEBOUNCE_TICKS) : cnt_q;
    idle_mid    = (|flip) ? 1'b0 : idle_q;
    settle_done = !idle_mid && (cnt_mid == '0);

    btn_d   = btn_q;
    cnt_d   = cnt_q;
    idle_d  = idle_q;
    light_d = light_q;

    if (is_scan) begin
      btn_d  = btn_mid;
      cnt_d  = cnt_mid;
      idle_d = idle_mid;
      if (settle_done) begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
          btn_d[i] = {1'b0, lvl[i]};
        end
        idle_d = 1'b1;
      end else if (!idle_mid) begin
        cnt_d = cnt_mid - CntW'(1);
      end
    end else begin
      for (int i = 0; i < ActLights; i++) begin
        case (light_act_e'(req_q.light_actions[ActW*i +: ActW]))
          ActKeep:   light_d[i] = light_q[i];
          ActOff:    light_d[i] = 1'b0;
          ActOn:     light_d[i] = 1'b1;
          ActToggle: light_d[i] = !light_q[i];
          default:   light_d[i] = light_q[i];
        endcase
      end
    end

    rsp_d              = '0;
    rsp_d.report_valid = is_scan && settle_done && rpt_en_q;
    for (int i = 0; i < RptBtn; i++) begin
      if (rsp_d.report_valid) begin
        rsp_d.report_states[StateW*i +: StateW] = btn_mid[i];
      end
      rsp_d.tracked_levels[i] = btn_d[i][0];
    end
    for (int i = 0; i < OutLights; i++) begin
      rsp_d.light_pattern[i] = light_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
      rpt_en_q  <= 1'b0;
      cnt_q     <= '0;
      idle_q    <= 1'b0;
      light_q   <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        btn_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        rpt_en_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        req_vld_q <= in_valid_i;
      end
      if (advance) begin
        rsp_vld_q <= req_vld_q;
      end
      if (fire) begin
        btn_q   <= btn_d;
        cnt_q   <= cnt_d;
        idle_q  <= idle_d;
        light_q <= light_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

`default_nettype wire

@@ src/bdll_checker.sv @@
// port-level assertions for the button debounce and light latch unit
`timescale 1ns / 1ps
`default_nettype none

module bdll_checker
  import bdll_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input wire req_t in_req_i,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire rsp_t out_rsp_o
);

  // no report means an all-zero state field
  a_no_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.report_valid |-> out_rsp_o.report_states == '0)
    else $error("report states set without a report");

  // a report is taken before reload, so the levels match the tracked levels
  a_report_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.report_valid |->
      out_rsp_o.report_states[0] == out_rsp_o.tracked_levels[0] &&
      out_rsp_o.report_states[2] == out_rsp_o.tracked_levels[1] &&
      out_rsp_o.report_states[4] == out_rsp_o.tracked_levels[2] &&
      out_rsp_o.report_states[6] == out_rsp_o.tracked_levels[3] &&
      out_rsp_o.report_states[8] == out_rsp_o.tracked_levels[4])
    else $error("reported levels differ from tracked levels");

  // the input side only stalls behind a stalled result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output is free");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("waiting request changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

endmodule

bind button_debounce_light_latch_unit bdll_checker u_bdll_checker (.*);

`default_nettype wire

@@ verif/button_debounce_light_latch_check.sv @@
// predictor and response compare for the button debounce and light latch unit
`timescale 1ns / 1ps

module button_debounce_light_latch_check
  import bdll_pkg::*;
#(
  parameter int BUTTON_COUNT   = DefButtonCount,
  parameter int LIGHT_COUNT    = DefLightCount,
  parameter int DEBOUNCE_TICKS = DefDebounceTicks
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  wire  in_ready_i,
  input  req_t in_req_i,
  input  wire  out_valid_i,
  input  wire  out_ready_i,
  input  rsp_t out_rsp_i,
  input  wire  cfg_we_i,
  input  wire  cfg_wdata_i,
  output int   error_count_o,
  output int   outstanding_o
);

  logic [StateW-1:0] btn_state [16];
  logic [3:0]        settle_cnt;
  logic              settle_idle;
  logic [15:0]       lights;
  logic              report_en;
  rsp_t              unit_outputs_q [$];

  function automatic rsp_t debounce_and_latch(input req_t r);
    rsp_t rsp;
    logic lvl;
    int   i;
    rsp = '0;
    if (cmd_e'(r.command) == CmdScan) begin
      for (i = 0; i < BUTTON_COUNT; i++) begin
        lvl = (i < BtnFieldW) ? r.button_levels[i] : 1'b0;
        if (btn_state[i][0] != lvl) begin
          settle_cnt   = 4'(DEBOUNCE_TICKS);
          settle_idle  = 1'b0;
          btn_state[i] = btn_state[i] ^ StateFlip;
        end
      end
      if (!settle_idle) begin
        if (settle_cnt == '0) begin
          if (report_en) begin
            rsp.report_valid = 1'b1;
            for (i = 0; i < BUTTON_COUNT && i < BtnFieldW; i++) begin
              rsp.report_states[2*i +: 2] = btn_state[i];
            end
          end
          for (i = 0; i < BUTTON_COUNT; i++) begin
            btn_state[i] = {1'b0, (i < BtnFieldW) ? r.button_levels[i] : 1'b0};
          end
          settle_idle = 1'b1;
        end else begin
          settle_cnt = settle_cnt - 4'd1;
        end
      end
    end else begin
      for (i = 0; i < LIGHT_COUNT && i < ActFieldW / ActW; i++) begin
        case (light_act_e'(r.light_actions[ActW*i +: ActW]))
          ActOff:    lights[i] = 1'b0;
          ActOn:     lights[i] = 1'b1;
          ActToggle: lights[i] = ~lights[i];
          default: ;
        endcase
      end
    end
    rsp.light_pattern = lights[LightFieldW-1:0];
    for (i = 0; i < BUTTON_COUNT && i < BtnFieldW; i++) begin
      rsp.tracked_levels[i] = btn_state[i][0];
    end
    return rsp;
  endfunction

  function automatic int field_mismatch(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) btn_state[i] = '0;
      settle_cnt    = '0;
      settle_idle   = 1'b0;
      lights        = '0;
      report_en     = 1'b0;
      unit_outputs_q.delete();
      error_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (unit_outputs_q.size() == 0) begin
          $error("response %0h with no request outstanding", out_rsp_i);
          error_count_o++;
        end else begin
          want = unit_outputs_q.pop_front();
          error_count_o += field_mismatch("light_pattern", 16'(want.light_pattern),
                                          16'(out_rsp_i.light_pattern));
          error_count_o += field_mismatch("report_valid", 16'(want.report_valid),
                                          16'(out_rsp_i.report_valid));
          error_count_o += field_mismatch("report_states", 16'(want.report_states),
                                          16'(out_rsp_i.report_states));
          error_count_o += field_mismatch("tracked_levels", 16'(want.tracked_levels),
                                          16'(out_rsp_i.tracked_levels));
        end
      end
      if (in_valid_i && in_ready_i) begin
        unit_outputs_q.push_back(debounce_and_latch(in_req_i));
      end
      if (cfg_we_i) begin
        report_en = cfg_wdata_i;
      end
      outstanding_o = unit_outputs_q.size();
    end
  end

endmodule

@@ verif/button_debounce_light_latch_unit_tb.sv @@
// testbench top: stimulus, handshake pacing and verdict for the debounce and light latch unit
`timescale 1ns / 1ps

module button_debounce_light_latch_unit_tb;
  import bdll_pkg::*;

  localparam int StallLimit = 1000;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready_o;
  req_t in_req;
  logic out_valid_o;
  logic out_ready;
  rsp_t out_rsp_o;
  logic cfg_we;
  logic cfg_wdata;
  int   error_count;
  int   outstanding;
  bit   tx_calm;
  bit   rx_calm;

  button_debounce_light_latch_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  button_debounce_light_latch_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready_o),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready),
    .out_rsp_i     (out_rsp_o),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_req(input cmd_e cmd, input logic [BtnFieldW-1:0] levels,
                          input logic [ActFieldW-1:0] actions);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req   <= '{command: cmd, button_levels: levels, light_actions: actions};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_report_enable(input logic value);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // mostly stable level runs, some long enough to settle, with bounces and light updates mixed in
  task automatic random_phase(input int n);
    int sent;
    int len;
    int k;
    logic [BtnFieldW-1:0] levels;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 3) != 0) begin
        levels = BtnFieldW'($urandom);
        len    = $urandom_range(1, 14);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0, 1: send_req(CmdLight, BtnFieldW'($urandom), ActFieldW'($urandom));
            2: send_req(CmdScan, levels ^ (BtnFieldW'(1) << $urandom_range(0, BtnFieldW - 1)),
                        ActFieldW'($urandom));
            default: send_req(CmdScan, levels, ActFieldW'($urandom));
          endcase
          sent++;
        end
      end else begin
        send_req(cmd_e'($urandom_range(0, 1)), BtnFieldW'($urandom), ActFieldW'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap(rx_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int i;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    tx_calm   = 1'b0;
    rx_calm   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first tick after reset reports, then light actions and a full settle
    write_report_enable(1'b1);
    send_req(CmdScan, 5'h00, 8'h00);
    send_req(CmdLight, 5'h00, 8'hAA);
    send_req(CmdLight, 5'h00, 8'h55);
    send_req(CmdLight, 5'h00, 8'hFF);
    send_req(CmdLight, 5'h00, 8'h00);
    send_req(CmdLight, 5'h1F, {ActToggle, ActOn, ActOff, ActKeep});
    send_req(CmdScan, 5'h00, 8'hFF);
    send_req(CmdScan, 5'h1F, 8'h00);
    for (i = 0; i < 12; i++) send_req(CmdScan, 5'h0A, 8'h00);
    send_req(CmdScan, 5'h15, 8'hFF);

    write_report_enable(1'b0);
    random_phase(125);
    write_report_enable(1'b1);
    random_phase(125);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    write_report_enable(1'b0);
    random_phase(125);
    tx_calm = 1'b0;
    write_report_enable(1'b1);
    random_phase(125);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
